// ===== hw/rtl/sss_pkg.sv =====
// Shared constants and types for the start-step-stop encoder.
`timescale 1ns / 1ps

package sss_pkg;

   localparam int CODE_BITS_DEF  = 64;
   localparam int VALUE_BITS_DEF = 32;

   // fixed field widths
   localparam int CODE_W    = 64;
   localparam int LEN_W     = 7;
   localparam int VALUE_W   = 32;
   localparam int WIDTH_W   = 6;
   localparam int RSP_DATA_W = 72;
   localparam int ADDR_W    = 3;
   localparam int CSR_DATA_W = 32;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [WIDTH_W-1:0] START_RESET = 6'd2;
   localparam logic [WIDTH_W-1:0] STEP_RESET  = 6'd2;

   // register index, taken from paddr[2]
   localparam logic REG_START = 1'b0;
   localparam logic REG_STEP  = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_FORM
   } state_type;

endpackage

// ===== hw/rtl/sss_queue.sv =====
// Small register queue between the front and back parts.
`timescale 1ns / 1ps

module sss_queue #(
   parameter int WIDTH = 33,
   parameter int DEPTH = sss_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             not_empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hw/rtl/sss_front.sv =====
// Input side: takes request beats, trims and classifies the value.
`timescale 1ns / 1ps

module sss_front #(
   parameter int VALUE_BITS = sss_pkg::VALUE_BITS_DEF
) (
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [sss_pkg::VALUE_W-1:0]   req_tdata,
   input  logic                          queue_full,
   output logic                          queue_push,
   output logic [VALUE_BITS:0]           queue_data   // {zero, value}
);

   import sss_pkg::*;

   logic [VALUE_BITS-1:0] value_trim;
   logic                  value_zero;

   assign value_trim = req_tdata[VALUE_BITS-1:0];
   assign value_zero = (value_trim == '0);

   assign req_tready = !queue_full;
   assign queue_push = req_tvalid && !queue_full;
   assign queue_data = {value_zero, value_trim};

endmodule

// ===== hw/rtl/sss_back.sv =====
// Back end: group search one group per cycle, then codeword build and result register.
`timescale 1ns / 1ps

module sss_back #(
   parameter int CODE_BITS  = sss_pkg::CODE_BITS_DEF,
   parameter int VALUE_BITS = sss_pkg::VALUE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [sss_pkg::WIDTH_W-1:0]   start_width,
   input  logic [sss_pkg::WIDTH_W-1:0]   step_width,
   input  logic                          queue_valid,
   input  logic [VALUE_BITS:0]           queue_data,   // {zero, value}
   output logic                          queue_pop,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [sss_pkg::RSP_DATA_W-1:0] rsp_tdata,   // code[63:0], code_length[70:64], pad
   output logic                          rsp_tuser     // error
);

   import sss_pkg::*;

   // holds w + step and n + w with w up to CODE_BITS-1 and step up to 63
   localparam int WW = $clog2(CODE_BITS + 64) + 1;

   state_type state_ff, state_in;

   logic [VALUE_BITS-1:0] rem_ff, rem_in;
   logic [WW-1:0]         w_ff, w_in;
   logic [WW-1:0]         n_ff, n_in;
   logic                  err_ff, err_in;

   logic                  out_valid_ff, out_valid_in;
   logic [CODE_W-1:0]     code_ff, code_in;
   logic [LEN_W-1:0]      len_ff, len_in;
   logic                  error_ff, error_in;

   logic [WW-1:0]         len_now;
   logic                  too_long;
   logic                  fits;
   logic                  out_free;
   logic [CODE_W-1:0]     mask_len;
   logic [CODE_W-1:0]     mask_low;

   assign len_now  = n_ff + w_ff;
   assign too_long = (len_now > WW'(CODE_BITS));
   assign fits     = ((rem_ff >> w_ff) == '0);
   assign out_free = !out_valid_ff || rsp_tready;

   // ones from bit w+1 up to bit len-1
   assign mask_len = ~({CODE_W{1'b1}} << len_now);
   assign mask_low = ~({CODE_W{1'b1}} << (w_ff + WW'(1)));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (queue_valid) begin
               state_in = queue_data[VALUE_BITS] ? ST_FORM : ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (too_long || fits) begin
               state_in = ST_FORM;
            end
         end
         ST_FORM: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rem_in       = rem_ff;
      w_in         = w_ff;
      n_in         = n_ff;
      err_in       = err_ff;
      queue_pop    = 1'b0;
      out_valid_in = out_valid_ff && !rsp_tready;
      code_in      = code_ff;
      len_in       = len_ff;
      error_in     = error_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (queue_valid) begin
               queue_pop = 1'b1;
               rem_in    = queue_data[VALUE_BITS-1:0] - VALUE_BITS'(1);
               w_in      = WW'(start_width);
               n_in      = WW'(1);
               err_in    = queue_data[VALUE_BITS];
            end
         end
         ST_SEARCH: begin
            if (too_long) begin
               err_in = 1'b1;
            end else if (!fits) begin
               rem_in = rem_ff - (VALUE_BITS'(1) << w_ff);
               w_in   = w_ff + WW'(step_width);
               n_in   = n_ff + WW'(1);
            end
         end
         ST_FORM: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               error_in     = err_ff;
               if (err_ff) begin
                  code_in = '0;
                  len_in  = '0;
               end else begin
                  code_in = CODE_W'(rem_ff) | (mask_len & ~mask_low);
                  len_in  = len_now[LEN_W-1:0];
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      w_ff     <= w_in;
      n_ff     <= n_in;
      err_ff   <= err_in;
      code_ff  <= code_in;
      len_ff   <= len_in;
      error_ff <= error_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - CODE_W - LEN_W){1'b0}}, len_ff, code_ff};
   assign rsp_tuser  = error_ff;

endmodule

// ===== hw/rtl/start_step_stop_encoder.sv =====
// Start-step-stop encoder: top level with register file, front, queue and back end.
// Path: queue, ST_IDLE pop, ST_SEARCH over n groups (1..65), ST_FORM, result reg; zero skips ST_SEARCH.
// The back end holds one item at a time, searching one group per cycle, and pops the next after ST_FORM.
// The queue takes new beats, until it is full, while the back end searches or a result waits.
// Synchronous active-high reset empties the queue and result register and sets both widths to 2.
`timescale 1ns / 1ps

module start_step_stop_encoder #(
   parameter int CODE_BITS  = sss_pkg::CODE_BITS_DEF,
   parameter int VALUE_BITS = sss_pkg::VALUE_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [sss_pkg::VALUE_W-1:0]     req_tdata,   // value[31:0]
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [sss_pkg::RSP_DATA_W-1:0]  rsp_tdata,   // code[63:0], code_length[70:64], pad
   output logic                            rsp_tuser,   // error
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [sss_pkg::ADDR_W-1:0]      csr_paddr,
   input  logic [sss_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [sss_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);

   import sss_pkg::*;

   logic [WIDTH_W-1:0] start_ff, start_in;
   logic [WIDTH_W-1:0] step_ff, step_in;
   logic               csr_write;

   logic               q_push, q_full, q_pop, q_valid;
   logic [VALUE_BITS:0] q_wdata, q_rdata;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      start_in = start_ff;
      step_in  = step_ff;
      if (csr_write) begin
         unique case (csr_paddr[2])
            REG_START: start_in = csr_pwdata[WIDTH_W-1:0];
            REG_STEP:  step_in  = csr_pwdata[WIDTH_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= START_RESET;
         step_ff  <= STEP_RESET;
      end else begin
         start_ff <= start_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[1:0] == 2'b00) begin
         unique case (csr_paddr[2])
            REG_START: csr_prdata = CSR_DATA_W'(start_ff);
            REG_STEP:  csr_prdata = CSR_DATA_W'(step_ff);
            default: ;
         endcase
      end
   end

   sss_front #(
      .VALUE_BITS (VALUE_BITS)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .queue_full (q_full),
      .queue_push (q_push),
      .queue_data (q_wdata)
   );

   sss_queue #(
      .WIDTH (VALUE_BITS + 1),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .not_empty (q_valid)
   );

   sss_back #(
      .CODE_BITS  (CODE_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .start_width (start_ff),
      .step_width  (step_ff),
      .queue_valid (q_valid),
      .queue_data  (q_rdata),
      .queue_pop   (q_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

endmodule
